### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module of the vector ALU.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, ignored while rst is high.
`define VIALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge of clk, reset cycles included.
`define VIALU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/vialu_pkg.sv
// ---------------------------------------------------------------------------
// vialu_pkg
// Operation codes, compare conditions and stage payload types of the ALU.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package vialu_pkg;

  // Operation codes.
  localparam logic [4:0] OP_MOV     = 5'd0;
  localparam logic [4:0] OP_ADD     = 5'd1;
  localparam logic [4:0] OP_SUB     = 5'd2;
  localparam logic [4:0] OP_SUBREV  = 5'd3;
  localparam logic [4:0] OP_AND     = 5'd4;
  localparam logic [4:0] OP_OR      = 5'd5;
  localparam logic [4:0] OP_XOR     = 5'd6;
  localparam logic [4:0] OP_NOT     = 5'd7;
  localparam logic [4:0] OP_SHL     = 5'd8;
  localparam logic [4:0] OP_SHR     = 5'd9;
  localparam logic [4:0] OP_ASR     = 5'd10;
  localparam logic [4:0] OP_SHR_A   = 5'd11;
  localparam logic [4:0] OP_MIN_S   = 5'd12;
  localparam logic [4:0] OP_MIN_U   = 5'd13;
  localparam logic [4:0] OP_MAX_S   = 5'd14;
  localparam logic [4:0] OP_MAX_U   = 5'd15;
  localparam logic [4:0] OP_MUL_LO  = 5'd16;
  localparam logic [4:0] OP_MUL_HI_S = 5'd17;
  localparam logic [4:0] OP_MUL_HI_U = 5'd18;
  localparam logic [4:0] OP_MUL24_S = 5'd19;
  localparam logic [4:0] OP_MAD24_S = 5'd20;
  localparam logic [4:0] OP_MAD24_U = 5'd21;
  localparam logic [4:0] OP_SAD     = 5'd22;
  localparam logic [4:0] OP_BFE_S   = 5'd23;
  localparam logic [4:0] OP_BFE_U   = 5'd24;
  localparam logic [4:0] OP_BFI     = 5'd25;
  localparam logic [4:0] OP_BCNT    = 5'd26;
  localparam logic [4:0] OP_BREV    = 5'd27;
  localparam logic [4:0] OP_CNDMASK = 5'd28;
  localparam logic [4:0] OP_CMP_S   = 5'd29;
  localparam logic [4:0] OP_CMP_U   = 5'd30;

  // Compare conditions.
  localparam logic [2:0] CMP_F  = 3'd0;
  localparam logic [2:0] CMP_EQ = 3'd1;
  localparam logic [2:0] CMP_NE = 3'd2;
  localparam logic [2:0] CMP_GT = 3'd3;
  localparam logic [2:0] CMP_LT = 3'd4;
  localparam logic [2:0] CMP_LE = 3'd5;
  localparam logic [2:0] CMP_GE = 3'd6;
  localparam logic [2:0] CMP_T  = 3'd7;

  localparam logic [4:0] SHIFT_MASK = 5'h1F;
  localparam int unsigned MUL24_WIDTH = 24;

  // Source of the final sum.
  localparam logic [1:0] SEL_BASE = 2'd0;
  localparam logic [1:0] SEL_LOW  = 2'd1;
  localparam logic [1:0] SEL_HIGH = 2'd2;

  typedef struct packed {
    logic [4:0]  operation;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic [2:0]  compare_kind;
    logic        select_flag;
  } vialu_req_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] addend;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [1:0]  sel;
    logic        carry_in;
    logic        compare_bit;
  } vialu_s1_t;

  typedef struct packed {
    logic [63:0] product;
    logic [31:0] base;
    logic [31:0] addend;
    logic [1:0]  sel;
    logic        carry_in;
    logic        compare_bit;
  } vialu_s2_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        compare_bit;
  } vialu_res_t;

endpackage

### rtl/vector_integer_alu.sv
// ---------------------------------------------------------------------------
// vector_integer_alu
// One lane of a 32-bit integer vector ALU in a three-stage pipeline.
// ---------------------------------------------------------------------------
// Usage: each request on the s_axis channel carries one instruction (operation,
// three operands and the compare condition in tdata, the select flag in tuser).
// Every request produces exactly one response on the m_axis channel, in order:
// the 32-bit result in tdata and the compare bit in tuser.
// The pipeline has three register stages, which a request passes in order; the
// third stage register drives m_axis. The first stage does logic, shifts,
// compares and bitfields, the second holds the 32 by 32 multiplier, the
// third the final adder that folds in addends and the signed high-product
// correction. Throughput is one request per cycle while the receiver takes
// responses; the block keeps no state between them.
// Each stage accepts whenever it is empty or its successor takes its content,
// so bubbles are squeezed out and a stalled receiver stops only what is queued
// behind the response it has not taken; s_axis_tready falls only once all
// three stages hold requests.
// Reset (rst, synchronous) empties the pipeline; no response is offered after it
// until new requests arrive.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_integer_alu import vialu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[4:0], operand_a[36:5], operand_b[68:37], operand_c[100:69],
  // compare_kind[103:101]
  input  logic [103:0] s_axis_tdata,
  // select_flag[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[31:0]
  output logic [31:0]  m_axis_tdata,
  // compare_bit[0]
  output logic [0:0]   m_axis_tuser
);

  vialu_req_t req;
  vialu_s1_t  s1_data;
  vialu_s2_t  s2_data;
  vialu_res_t res;
  logic       s1_valid, s1_ready;
  logic       s2_valid, s2_ready;

  // Unpack the request payload.
  assign req.operation    = s_axis_tdata[4:0];
  assign req.operand_a    = s_axis_tdata[36:5];
  assign req.operand_b    = s_axis_tdata[68:37];
  assign req.operand_c    = s_axis_tdata[100:69];
  assign req.compare_kind = s_axis_tdata[103:101];
  assign req.select_flag  = s_axis_tuser[0];

  vialu_alu_stage u_alu (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (req),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  vialu_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // The last stage register is the output register of the block.
  vialu_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata    = res.result_value;
  assign m_axis_tuser[0] = res.compare_bit;

endmodule

### rtl/vialu_alu_stage.sv
// ---------------------------------------------------------------------------
// vialu_alu_stage
// First stage: logic, shifts, compares, bitfields; prepares multiplier inputs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vialu_alu_stage import vialu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  vialu_req_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output vialu_s1_t  out_data
);

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [3:0] part [4];
    logic [5:0] total;
    for (int k = 0; k < 4; k++) begin
      part[k] = 4'd0;
      for (int i = 0; i < 8; i++) begin
        part[k] = part[k] + {3'd0, v[8*k+i]};
      end
    end
    total = {2'd0, part[0]} + {2'd0, part[1]} + {2'd0, part[2]} + {2'd0, part[3]};
    return total;
  endfunction

  function automatic logic compare32(input logic [31:0] x, input logic [31:0] y,
                                     input logic [2:0] kind);
    logic r;
    unique case (kind)
      CMP_F:   r = 1'b0;
      CMP_EQ:  r = (x == y);
      CMP_NE:  r = (x != y);
      CMP_GT:  r = (x > y);
      CMP_LT:  r = (x < y);
      CMP_LE:  r = (x <= y);
      CMP_GE:  r = (x >= y);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  logic [31:0] a, b, c;
  logic [4:0]  sh_a, sh_b, wid;
  logic        lt_s, lt_u, gt_s, gt_u;
  logic [31:0] abs_gap, field, fmask, bf_u, bf_s, rev, corr;
  logic [31:0] flip;
  vialu_s1_t   s1_next;
  logic        valid;
  vialu_s1_t   data;

  assign a    = in_data.operand_a;
  assign b    = in_data.operand_b;
  assign c    = in_data.operand_c;
  assign sh_a = a[4:0] & SHIFT_MASK;
  assign sh_b = b[4:0] & SHIFT_MASK;
  assign wid  = c[4:0] & SHIFT_MASK;
  assign flip = 32'h8000_0000;

  assign lt_s = (a ^ flip) < (b ^ flip);
  assign gt_s = (a ^ flip) > (b ^ flip);
  assign lt_u = a < b;
  assign gt_u = a > b;

  assign abs_gap = gt_u ? (a - b) : (b - a);

  // Bitfield extract: field from bit sh_b, wid bits, sign taken from its top bit.
  assign fmask = (32'h1 << wid) - 32'h1;
  assign field = (a >> sh_b) & fmask;
  assign bf_u  = field;
  assign bf_s  = field[wid - 5'd1] ? (field | ~fmask) : field;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      rev[i] = a[31 - i];
    end
  end

  // Signed high product = unsigned high product minus this correction.
  assign corr = (a[31] ? b : 32'd0) + (b[31] ? a : 32'd0);

  always_comb begin
    s1_next             = '0;
    s1_next.sel         = SEL_BASE;
    s1_next.mul_a       = a;
    s1_next.mul_b       = b;
    case (in_data.operation) inside
      OP_MOV:     s1_next.base = a;
      OP_ADD:     s1_next.base = a + b;
      OP_SUB:     s1_next.base = a - b;
      OP_SUBREV:  s1_next.base = b - a;
      OP_AND:     s1_next.base = a & b;
      OP_OR:      s1_next.base = a | b;
      OP_XOR:     s1_next.base = a ^ b;
      OP_NOT:     s1_next.base = ~a;
      OP_SHL:     s1_next.base = b << sh_a;
      OP_SHR:     s1_next.base = b >> sh_a;
      OP_ASR:     s1_next.base = $unsigned($signed(b) >>> sh_a);
      OP_SHR_A:   s1_next.base = a >> sh_b;
      OP_MIN_S:   s1_next.base = lt_s ? a : b;
      OP_MIN_U:   s1_next.base = lt_u ? a : b;
      OP_MAX_S:   s1_next.base = gt_s ? a : b;
      OP_MAX_U:   s1_next.base = gt_u ? a : b;
      OP_MUL_LO:  s1_next.sel = SEL_LOW;
      OP_MUL_HI_S: begin
        s1_next.sel      = SEL_HIGH;
        s1_next.addend   = ~corr;
        s1_next.carry_in = 1'b1;
      end
      OP_MUL_HI_U: s1_next.sel = SEL_HIGH;
      OP_MUL24_S, OP_MAD24_S: begin
        s1_next.sel    = SEL_LOW;
        s1_next.mul_a  = {{(32 - MUL24_WIDTH){a[MUL24_WIDTH-1]}}, a[MUL24_WIDTH-1:0]};
        s1_next.mul_b  = {{(32 - MUL24_WIDTH){b[MUL24_WIDTH-1]}}, b[MUL24_WIDTH-1:0]};
        s1_next.addend = (in_data.operation == OP_MAD24_S) ? c : 32'd0;
      end
      OP_MAD24_U: begin
        s1_next.sel    = SEL_LOW;
        s1_next.mul_a  = {{(32 - MUL24_WIDTH){1'b0}}, a[MUL24_WIDTH-1:0]};
        s1_next.mul_b  = {{(32 - MUL24_WIDTH){1'b0}}, b[MUL24_WIDTH-1:0]};
        s1_next.addend = c;
      end
      OP_SAD: begin
        s1_next.base   = abs_gap;
        s1_next.addend = c;
      end
      OP_BFE_S:   s1_next.base = bf_s;
      OP_BFE_U:   s1_next.base = bf_u;
      OP_BFI:     s1_next.base = (a & b) | (~a & c);
      OP_BCNT: begin
        s1_next.base   = {26'd0, popcount32(a)};
        s1_next.addend = b;
      end
      OP_BREV:    s1_next.base = rev;
      OP_CNDMASK: s1_next.base = in_data.select_flag ? b : a;
      OP_CMP_S:   s1_next.compare_bit = compare32(a ^ flip, b ^ flip, in_data.compare_kind);
      OP_CMP_U:   s1_next.compare_bit = compare32(a, b, in_data.compare_kind);
      default:    s1_next.base = 32'd0;
    endcase
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= s1_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### rtl/vialu_mul_stage.sv
// ---------------------------------------------------------------------------
// vialu_mul_stage
// Second stage: the 32 by 32 unsigned multiplier, product registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vialu_mul_stage import vialu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  vialu_s1_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output vialu_s2_t out_data
);

  logic      valid;
  vialu_s2_t data;
  vialu_s2_t s2_next;

  always_comb begin
    s2_next.product     = {32'd0, in_data.mul_a} * {32'd0, in_data.mul_b};
    s2_next.base        = in_data.base;
    s2_next.addend      = in_data.addend;
    s2_next.sel         = in_data.sel;
    s2_next.carry_in    = in_data.carry_in;
    s2_next.compare_bit = in_data.compare_bit;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= s2_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### rtl/vialu_sum_stage.sv
// ---------------------------------------------------------------------------
// vialu_sum_stage
// Third stage: picks base, low or high product and adds the addend and carry-in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vialu_sum_stage import vialu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  vialu_s2_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output vialu_res_t out_data
);

  logic       valid;
  vialu_res_t data;
  vialu_res_t res_next;
  logic [31:0] x;

  always_comb begin
    unique case (in_data.sel)
      SEL_LOW:  x = in_data.product[31:0];
      SEL_HIGH: x = in_data.product[63:32];
      default:  x = in_data.base;
    endcase
    res_next.result_value = x + in_data.addend + {31'd0, in_data.carry_in};
    res_next.compare_bit  = in_data.compare_bit;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= res_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### rtl/vialu_checker.sv
// ---------------------------------------------------------------------------
// vialu_checker
// Port-level checks of the vector ALU, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vialu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Reset empties the pipeline.
  `VIALU_ASSERT_RST(a_reset_empty, rst |=> !m_axis_tvalid, "response offered after reset")

  // A set compare bit only comes from a compare, whose value is zero.
  `VIALU_ASSERT(a_cmp_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0), "compare response with nonzero value")

  // Requests are refused only when every stage is full behind a stalled response.
  `VIALU_ASSERT(a_ready_full, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "request refused without a stalled response")

  // A stalled response keeps its payload.
  `VIALU_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser) && m_axis_tvalid), "stalled response changed")

endmodule

bind vector_integer_alu vialu_checker u_checker (.*);
